### src/pmt_pkg.sv
// Shared types and constants for the pipe mailbox table.
// No dependencies; everything else in src imports this package.
`timescale 1ns / 1ps

package pmt_pkg;

  localparam int REQ_W    = 2;
  localparam int SLOT_W   = 3;
  localparam int PID_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_OPEN = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RECV = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INACTIVE      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SENDER_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RECEIVER_FULL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_PID       = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY         = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LOOK,
    S_READ,
    S_FIN
  } pmt_state_t;

  // Outcome of comparing two pids against one slot's owner pair.
  // box: 0 selects owner a's mailbox, 1 owner b's.
  typedef struct packed {
    logic pair;
    logic x_own;
    logic x_box;
    logic y_own;
    logic y_box;
  } pmt_hit_t;

endpackage

### src/pmt_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on pmt_pkg for field widths.
`timescale 1ns / 1ps

interface pmt_in_if;
  import pmt_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SLOT_W-1:0]   pipe_index;
  logic [PID_W-1:0]    first_pid;
  logic [PID_W-1:0]    second_pid;
  logic [VAL_W-1:0]    message_value;

  modport source (
    output valid, req_type, pipe_index, first_pid, second_pid, message_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, pipe_index, first_pid, second_pid, message_value,
    output ready
  );
endinterface

interface pmt_out_if;
  import pmt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   pipe_result;
  logic [VAL_W-1:0]    received_value;

  modport source (
    output valid, status, pipe_result, received_value,
    input  ready
  );
  modport sink (
    input  valid, status, pipe_result, received_value,
    output ready
  );
endinterface

### src/pmt_match.sv
// Pid compare unit: matches two pids against one owner pair.
// Shared by the open scan and the send/receive lookup. Uses pmt_pkg.
`timescale 1ns / 1ps

module pmt_match (
  input  logic [pmt_pkg::PID_W-1:0] owner_a,
  input  logic [pmt_pkg::PID_W-1:0] owner_b,
  input  logic [pmt_pkg::PID_W-1:0] pid_x,
  input  logic [pmt_pkg::PID_W-1:0] pid_y,
  output pmt_pkg::pmt_hit_t         hit
);
  import pmt_pkg::*;

  logic ax, bx, ay, by;

  assign ax = (owner_a == pid_x);
  assign bx = (owner_b == pid_x);
  assign ay = (owner_a == pid_y);
  assign by = (owner_b == pid_y);

  // owner a wins when both owners carry the same pid
  always_comb begin
    hit.pair  = (ax && by) || (ay && bx);
    hit.x_own = ax || bx;
    hit.x_box = !ax;
    hit.y_own = ay || by;
    hit.y_box = !ay;
  end

endmodule

### src/pipe_mailbox_table_top.sv
// Top level of the pipe mailbox table: sequencer, slot/mailbox storage.
// Depends on pmt_pkg, pmt_if (channel interfaces) and pmt_match.
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// --------  ---  --------------------------------------------------------
// in_ch     in   req_type, pipe_index, first_pid, second_pid, message_value
// out_ch    out  status, pipe_result, received_value (one per request)
//
// Flow: one request at a time; ready is high only while idle. Open walks
// the slots through the single owner memory read port, one slot a cycle,
// with the pid compare unit checking each read in the cycle after it; open
// stops early on a hit. Receive adds a mailbox word read state that send
// does not have. Reset clears slot and full flags at once; no clearing
// pass. The result register decouples the sides: a stalled result holds
// in out_ch while the next request is accepted.
module pipe_mailbox_table_top #(
  parameter int PIPE_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  pmt_in_if.sink    in_ch,
  pmt_out_if.source out_ch
);
  import pmt_pkg::*;

  // Slot address width, scan counter width (holds PIPE_COUNT), and a
  // width wide enough for both the slot field and the counter.
  localparam int AW = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  localparam int CW = $clog2(PIPE_COUNT + 1);
  localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int OW = 2 * PID_W;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  pmt_state_t state_r, state_nxt;

  // latched request
  logic [REQ_W-1:0] req_type_r;
  logic [AW-1:0]    req_slot_r;
  logic             req_inrange_r;
  logic [PID_W-1:0] req_p1_r;
  logic [PID_W-1:0] req_p2_r;
  logic [VAL_W-1:0] req_val_r;

  // scan state
  logic [CW-1:0] idx_r;
  logic          q_vld_r;
  logic [AW-1:0] q_idx_r;
  logic          free_found_r;
  logic [AW-1:0] free_idx_r;

  // slot flags (reset-cleared)
  logic [PIPE_COUNT-1:0] active_r;
  logic [PIPE_COUNT-1:0] full_a_r;
  logic [PIPE_COUNT-1:0] full_b_r;

  // storage
  logic [OW-1:0]    own_mem [PIPE_COUNT];
  logic [OW-1:0]    own_q_r;
  logic [VAL_W-1:0] word_mem [2*PIPE_COUNT];
  logic [VAL_W-1:0] word_q_r;

  // pending result and output register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_pipe_r, res_pipe_nxt;
  logic [VAL_W-1:0]    res_value_r, res_value_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_pipe_r;
  logic [VAL_W-1:0]    out_value_r;

  pmt_hit_t hit;

  logic          accept;
  logic [XW-1:0] in_slot_x;
  logic          in_inrange;
  logic          issue;
  logic [AW-1:0] own_raddr;
  logic          own_we;
  logic [AW-1:0] alloc_idx;
  logic          scan_hit, scan_free, scan_last, alloc_ok;
  logic          slot_act, x_full, y_full;
  logic          word_we;
  logic [AW:0]   word_addr;
  logic          set_full, clr_full;
  logic          out_load;

  assign accept     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_slot_x  = XW'(in_ch.pipe_index);
  assign in_inrange = (in_slot_x < XW'(PIPE_COUNT));

  // scan issues one owner read per cycle until every slot has gone out
  assign issue = (state_r == S_SCAN) && (idx_r < CW'(PIPE_COUNT));

  always_comb begin
    own_raddr = '0;
    if (state_r == S_SCAN) begin
      if (issue) own_raddr = idx_r[AW-1:0];
    end else if (in_inrange) begin
      own_raddr = in_slot_x[AW-1:0];
    end
  end

  pmt_match u_match (
    .owner_a (own_q_r[OW-1:PID_W]),
    .owner_b (own_q_r[PID_W-1:0]),
    .pid_x   (req_p1_r),
    .pid_y   (req_p2_r),
    .hit     (hit)
  );

  // scan compare checks each read in the cycle after it issues
  assign scan_hit  = q_vld_r && active_r[q_idx_r] && hit.pair;
  assign scan_free = q_vld_r && !active_r[q_idx_r];
  assign scan_last = q_vld_r && (q_idx_r == AW'(PIPE_COUNT - 1));
  assign alloc_ok  = free_found_r || scan_free;
  assign alloc_idx = free_found_r ? free_idx_r : q_idx_r;

  // send/receive lookup
  assign slot_act  = req_inrange_r && active_r[req_slot_r];
  assign x_full    = hit.x_box ? full_b_r[req_slot_r] : full_a_r[req_slot_r];
  assign y_full    = hit.y_box ? full_b_r[req_slot_r] : full_a_r[req_slot_r];
  assign out_load  = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_pipe_nxt   = res_pipe_r;
    res_value_nxt  = res_value_r;
    own_we         = 1'b0;
    word_we        = 1'b0;
    word_addr      = {req_slot_r, 1'b0};
    set_full       = 1'b0;
    clr_full       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_INACTIVE;
          res_pipe_nxt   = '0;
          res_value_nxt  = '0;
          unique case (in_ch.req_type)
            REQ_OPEN:           state_nxt = S_SCAN;
            REQ_SEND, REQ_RECV: state_nxt = S_LOOK;
            default:            state_nxt = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_status_nxt = ST_OK;
          res_pipe_nxt   = SLOT_W'(XW'(q_idx_r));
          state_nxt      = S_FIN;
        end else if (scan_last) begin
          if (alloc_ok) begin
            own_we         = 1'b1;
            res_status_nxt = ST_OK;
            res_pipe_nxt   = SLOT_W'(XW'(alloc_idx));
          end else begin
            res_status_nxt = ST_NO_FREE;
          end
          state_nxt = S_FIN;
        end
      end
      S_LOOK: begin
        state_nxt = S_FIN;
        if (!slot_act) begin
          res_status_nxt = ST_INACTIVE;
        end else if (req_type_r == REQ_SEND) begin
          word_addr = {req_slot_r, hit.y_box};
          if (!(hit.x_own && hit.y_own)) begin
            res_status_nxt = ST_BAD_PID;
          end else if (x_full) begin
            res_status_nxt = ST_SENDER_FULL;
          end else if (y_full) begin
            res_status_nxt = ST_RECEIVER_FULL;
          end else begin
            word_we        = 1'b1;
            set_full       = 1'b1;
            res_status_nxt = ST_OK;
          end
        end else begin
          word_addr = {req_slot_r, hit.x_box};
          if (!hit.x_own) begin
            res_status_nxt = ST_BAD_PID;
          end else if (!x_full) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            clr_full       = 1'b1;
            res_status_nxt = ST_OK;
            state_nxt      = S_READ;
          end
        end
      end
      S_READ: begin
        res_value_nxt = word_q_r;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      full_a_r     <= '0;
      full_b_r     <= '0;
      out_valid_r  <= 1'b0;
      q_vld_r      <= 1'b0;
      free_found_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r <= state_nxt;
      q_vld_r <= issue;

      if (state_r == S_IDLE) begin
        idx_r        <= '0;
        free_found_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        if (issue) idx_r <= idx_r + CW'(1);
        if (scan_free && !free_found_r) free_found_r <= 1'b1;
      end

      // allocation: mark active, both mailboxes empty
      if (own_we) begin
        active_r[alloc_idx] <= 1'b1;
        full_a_r[alloc_idx] <= 1'b0;
        full_b_r[alloc_idx] <= 1'b0;
      end
      if (set_full) begin
        if (hit.y_box) full_b_r[req_slot_r] <= 1'b1;
        else           full_a_r[req_slot_r] <= 1'b1;
      end
      if (clr_full) begin
        if (hit.x_box) full_b_r[req_slot_r] <= 1'b0;
        else           full_a_r[req_slot_r] <= 1'b0;
      end

      if (state_r == S_FIN && out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready)            out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers and memories
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r    <= in_ch.req_type;
      req_slot_r    <= in_inrange ? in_slot_x[AW-1:0] : '0;
      req_inrange_r <= in_inrange;
      req_p1_r      <= in_ch.first_pid;
      req_p2_r      <= in_ch.second_pid;
      req_val_r     <= in_ch.message_value;
    end
    q_idx_r <= idx_r[AW-1:0];
    if (state_r == S_SCAN && scan_free && !free_found_r) free_idx_r <= q_idx_r;

    res_status_r <= res_status_nxt;
    res_pipe_r   <= res_pipe_nxt;
    res_value_r  <= res_value_nxt;

    if (state_r == S_FIN && out_load) begin
      out_status_r <= res_status_r;
      out_pipe_r   <= res_pipe_r;
      out_value_r  <= res_value_r;
    end
  end

  // owner pair store: one write, one registered read
  always_ff @(posedge clk) begin
    if (own_we) own_mem[alloc_idx] <= {req_p1_r, req_p2_r};
    own_q_r <= own_mem[own_raddr];
  end

  // mailbox words: entry {slot, box}
  always_ff @(posedge clk) begin
    if (word_we) word_mem[word_addr] <= req_val_r;
    word_q_r <= word_mem[word_addr];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.pipe_result    = out_pipe_r;
  assign out_ch.received_value = out_value_r;

endmodule
